>>> hw/rtl/sbs_pkg.sv
// Shared types and constants for the sorted table binary search block.
package sbs_pkg;

  // Table geometry; the 4-bit index fields fix the depth at 16.
  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int PTR_W       = $clog2(TABLE_DEPTH + 1);
  localparam int VAL_W       = 32;
  localparam int CNT_W       = 5;
  localparam int FIELD_IDX_W = 4;

  localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(16);

  typedef enum logic {
    FUNC_WRITE  = 1'b0,
    FUNC_SEARCH = 1'b1
  } func_e;

  typedef enum logic {
    ST_IDLE,
    ST_PROBE
  } state_e;

  typedef struct packed {
    func_e                   func;
    logic [FIELD_IDX_W-1:0]  entry_index;
    logic signed [VAL_W-1:0] write_value;
    logic signed [VAL_W-1:0] search_key;
  } sbs_req_t;

  typedef struct packed {
    logic                   found;
    logic [FIELD_IDX_W-1:0] match_index;
  } sbs_rsp_t;

  // Controller -> datapath
  typedef struct packed {
    logic write;   // store the accepted entry
    logic start;   // load key and initial range
    logic step;    // narrow the range after a probe
    logic finish;  // capture result into the output register
  } sbs_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic cur_empty;   // current range holds nothing
    logic hit;         // probed entry equals key
    logic next_empty;  // range after this probe holds nothing
  } sbs_status_t;

endpackage

>>> hw/rtl/sbs_ram.sv
// Generic simple dual-port RAM with registered read data.
module sbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/sbs_ctrl.sv
// Sequencing FSM for the binary search block.
module sbs_ctrl import sbs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  func_e       in_func_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output sbs_cmd_t    cmd_o,
  input  sbs_status_t status_i
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   done_now;
  logic   slot_free;

  assign done_now  = status_i.cur_empty | status_i.hit | status_i.next_empty;
  assign slot_free = ~out_valid_q | out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && (in_func_i == FUNC_SEARCH)) begin
          state_d = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (done_now && slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.write  = in_valid_i && (in_func_i == FUNC_WRITE);
        cmd_o.start  = in_valid_i && (in_func_i == FUNC_SEARCH);
      end
      ST_PROBE: begin
        cmd_o.step   = ~done_now;
        cmd_o.finish = done_now & slot_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  ap_finish_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> out_valid_q)
    else $error("result captured but not presented");

  ap_cmd_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |-> !cmd_o.step && !cmd_o.finish && !cmd_o.write)
    else $error("start overlaps another command");

  ap_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q)
    else $error("response dropped before acceptance");

endmodule

>>> hw/rtl/sbs_dp.sv
// Datapath: table RAM, search range, key, count register and result register.
module sbs_dp import sbs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sbs_req_t          req_i,
  input  logic              cfg_we_i,
  input  logic [CNT_W-1:0]  cfg_wdata_i,
  input  sbs_cmd_t          cmd_i,
  output sbs_status_t       status_o,
  output sbs_rsp_t          rsp_o
);

  localparam int CmpW = (CNT_W > PTR_W) ? CNT_W : PTR_W;

  // Midpoint of the half-open range [lo, hi): floor((lo + hi - 1) / 2).
  function automatic logic [IDX_W-1:0] mid_of(input logic [PTR_W-1:0] lo,
                                               input logic [PTR_W-1:0] hi);
    logic [PTR_W:0] sum;
    sum = {1'b0, lo} + {1'b0, hi} - (PTR_W+1)'(1);
    return sum[IDX_W:1];
  endfunction

  logic [CNT_W-1:0]        cnt_q;
  logic [PTR_W-1:0]        lo_q, lo_d, hi_q, hi_d;
  logic [PTR_W-1:0]        lo_n, hi_n, n_lim;
  logic signed [VAL_W-1:0] key_q;
  logic signed [VAL_W-1:0] probe;
  logic [VAL_W-1:0]        rdata;
  logic [IDX_W-1:0]        mid, raddr;
  logic [PTR_W-1:0]        mid_ext;
  logic                    less, we;
  sbs_rsp_t                rsp_q;

  // Count above the table depth covers the whole table.
  assign n_lim = (CmpW'(cnt_q) > CmpW'(TABLE_DEPTH)) ? PTR_W'(TABLE_DEPTH)
                                                     : PTR_W'(cnt_q);

  assign we = cmd_i.write && (32'(req_i.entry_index) < 32'(TABLE_DEPTH));

  assign mid     = mid_of(lo_q, hi_q);
  assign mid_ext = PTR_W'(mid);
  assign probe   = $signed(rdata);
  assign less    = key_q < probe;

  always_comb begin
    if (less) begin
      lo_n = lo_q;
      hi_n = mid_ext;
    end else begin
      lo_n = mid_ext + PTR_W'(1);
      hi_n = hi_q;
    end
  end

  assign status_o.cur_empty  = lo_q >= hi_q;
  assign status_o.hit        = probe == key_q;
  assign status_o.next_empty = lo_n >= hi_n;

  always_comb begin
    lo_d = lo_q;
    hi_d = hi_q;
    if (cmd_i.start) begin
      lo_d = '0;
      hi_d = n_lim;
    end else if (cmd_i.step) begin
      lo_d = lo_n;
      hi_d = hi_n;
    end
  end

  // Address follows the next range so the registered read data matches the current range.
  assign raddr = mid_of(lo_d, hi_d);

  sbs_ram #(
    .WIDTH (VAL_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (IDX_W'(req_i.entry_index)),
    .wdata_i (req_i.write_value),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= CNT_RESET;
      lo_q  <= '0;
      hi_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        cnt_q <= cfg_wdata_i;
      end
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      key_q <= req_i.search_key;
    end
    if (cmd_i.finish) begin
      rsp_q.found       <= ~status_o.cur_empty & status_o.hit;
      rsp_q.match_index <= (~status_o.cur_empty & status_o.hit) ? FIELD_IDX_W'(mid)
                                                                : '0;
    end
  end

  assign rsp_o = rsp_q;

  ap_step_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> lo_q < hi_q)
    else $error("step taken on an empty range");

  ap_range_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |=> (hi_q - lo_q) < $past(hi_q - lo_q))
    else $error("search range did not shrink");

  ap_range_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lo_q <= PTR_W'(TABLE_DEPTH) && hi_q <= PTR_W'(TABLE_DEPTH))
    else $error("search range beyond table");

endmodule

>>> hw/rtl/sorted_table_binary_search_top.sv
// Top level of the sorted table binary search block.
//
// Requests arrive on the in channel (valid/ready). A write request stores
// write_value at entry_index in the 16-entry table and produces no response.
// A search request runs a binary search over the first entry_count entries
// and returns one response (found, match_index) on the out channel
// (valid/ready).
// A search probes one midpoint per cycle from a registered-read RAM until the
// key is hit or the range empties; the response is then captured in the
// output register once the output slot is free. The single compare-and-halve
// loop takes no new request until the search is done; writes go at one per
// cycle while no search is running.
// entry_count is written through cfg_we_i / cfg_wdata_i; values above 16
// cover the whole table, zero gives a miss. Write it only while idle.
// Reset clears the controller and sets entry_count to 16; table contents are
// undefined until written, so software loads them (ascending) before searching.
// While the receiver stalls, the response is held; new requests are still
// taken, and a following search waits in its last probe until the slot frees.
module sorted_table_binary_search_top import sbs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  sbs_req_t         in_req_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output sbs_rsp_t         out_rsp_o,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i
);

  sbs_cmd_t    cmd;
  sbs_status_t status;

  // Sequencer: handshakes and command issue.
  sbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_func_i   (in_req_i.func),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // Table storage, range tracking and response register.
  sbs_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (in_req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .rsp_o       (out_rsp_o)
  );

endmodule
